// ----- design/cgtm_pkg.sv -----
// Shared types, constants and a helper function of the coaxial gimbal thrust mixer.
`timescale 1ns / 1ps
`default_nettype none
package cgtm_pkg;

	// Depth of the queue between the front end and the solver.
	localparam int unsigned DEF_QUEUE_DEPTH = 2;

	// Configuration port.
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LIFT_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRAG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRAG_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVER_ARM   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_THRUST  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MOMENT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_LIMIT = 3'd7;

	// Reset values, Q16.16.
	localparam logic [30:0] RST_LIFT_GAIN   = 31'd672694;
	localparam logic [30:0] RST_DRAG_GAIN   = 31'd13972;
	localparam logic [31:0] RST_LIFT_OFFSET = 32'hFFFD_073F;
	localparam logic [31:0] RST_DRAG_OFFSET = 32'd282;
	localparam logic [30:0] RST_LEVER_ARM   = 31'd1966;
	localparam logic [30:0] RST_MAX_THRUST  = 31'd983040;
	localparam logic [30:0] RST_MAX_MOMENT  = 31'd6554;
	localparam logic [30:0] RST_SERVO_LIMIT = 31'd1966080;

	// Minimum thrust (0.1) and the radian to degree factor, Q16.16.
	localparam logic [30:0] MIN_THRUST = 31'd6554;
	localparam logic [21:0] RAD_TO_DEG = 22'd3754936;

	typedef struct packed {
		logic [30:0] lift_gain;
		logic [30:0] drag_gain;
		logic [31:0] lift_offset;
		logic [31:0] drag_offset;
		logic [30:0] lever_arm;
		logic [30:0] max_thrust;
		logic [30:0] max_moment;
		logic [30:0] servo_limit;
	} cgtm_cfg_t;

	// One demand set after the front end has summed and clamped it.
	typedef struct packed {
		logic [30:0] thrust;
		logic [31:0] yaw;
		logic [31:0] roll;
		logic [31:0] pitch;
		logic        thrust_low;
		logic        thrust_high;
		logic        roll_hit;
		logic        pitch_hit;
	} cgtm_item_t;

	typedef struct packed {
		logic [31:0] servo_x_angle;
		logic [31:0] servo_y_angle;
		logic [31:0] upper_rotor_cmd;
		logic [31:0] lower_rotor_cmd;
		logic        thrust_low_hit;
		logic        thrust_high_hit;
		logic        yaw_hit;
		logic        roll_hit;
		logic        pitch_hit;
	} cgtm_result_t;

	// Saturate a wide two's complement value to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic [50:0] x);
		logic fits;
		fits = (&x[50:31]) || !(|x[50:31]);
		if (fits) begin
			return x[31:0];
		end
		return x[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

endpackage
`default_nettype wire

// ----- design/cgtm_div.sv -----
// Restoring divider that develops one quotient bit per clock cycle.
`timescale 1ns / 1ps
`default_nettype none
module cgtm_div
	import cgtm_pkg::*;
#(
	parameter int unsigned DW = 31,
	parameter int unsigned QW = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] den,
	input  wire logic [DW-1:0] rem_init,
	input  wire logic [QW-1:0] dividend_bits,
	output logic               busy,
	output logic [QW-1:0]      quot
);
	localparam int unsigned CW = $clog2(QW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] bits_q;
	logic [QW-1:0] quot_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          take;

	// The partial remainder stays below the divisor, so one trial subtract per bit.
	assign shifted = {rem_q, bits_q[QW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign take    = shifted >= {1'b0, den_q};
	assign busy    = cnt_q != '0;
	assign quot    = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			den_q  <= den;
			bits_q <= dividend_bits;
		end else if (busy) begin
			rem_q  <= take ? diff[DW-1:0] : shifted[DW-1:0];
			bits_q <= bits_q << 1;
			quot_q <= {quot_q[QW-2:0], take};
		end
	end

endmodule
`default_nettype wire

// ----- design/cgtm_front.sv -----
// Front end: takes demand sets, sums feed-forward terms and applies the thrust and moment clamps.
`timescale 1ns / 1ps
`default_nettype none
module cgtm_front
	import cgtm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] throttle_demand,
	input  wire logic [31:0] roll_demand,
	input  wire logic [31:0] roll_feedfwd,
	input  wire logic [31:0] pitch_demand,
	input  wire logic [31:0] pitch_feedfwd,
	input  wire logic [31:0] yaw_demand,
	input  wire logic [31:0] yaw_feedfwd,
	input  wire logic [30:0] max_thrust,
	input  wire logic [30:0] max_moment,
	input  wire logic        q_full,
	output logic             q_push,
	output cgtm_item_t       q_item,
	output logic             busy
);
	logic       valid_s1;
	cgtm_item_t item_s1;
	cgtm_item_t item_next;
	logic       accept;
	logic [32:0] roll_c;
	logic [32:0] pitch_c;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [50:0] s;
		s = {{19{a[31]}}, a} + {{19{b[31]}}, b};
		return sat32(s);
	endfunction

	// Returns {hit, value}: the value limited to +/- lim in magnitude.
	function automatic logic [32:0] clamp_mom(input logic [31:0] x, input logic [30:0] lim);
		logic [31:0] mag;
		logic [31:0] lim_w;
		mag   = x[31] ? (32'd0 - x) : x;
		lim_w = {1'b0, lim};
		if (mag > lim_w) begin
			return {1'b1, x[31] ? (32'd0 - lim_w) : lim_w};
		end
		return {1'b0, x};
	endfunction

	assign roll_c  = clamp_mom(sat_add(roll_demand, roll_feedfwd), max_moment);
	assign pitch_c = clamp_mom(sat_add(pitch_demand, pitch_feedfwd), max_moment);

	always_comb begin
		item_next             = '0;
		item_next.yaw         = sat_add(yaw_demand, yaw_feedfwd);
		item_next.roll        = roll_c[31:0];
		item_next.roll_hit    = roll_c[32];
		item_next.pitch       = pitch_c[31:0];
		item_next.pitch_hit   = pitch_c[32];
		// The maximum test only runs when the minimum test passes.
		if ($signed(throttle_demand) < $signed({1'b0, MIN_THRUST})) begin
			item_next.thrust     = MIN_THRUST;
			item_next.thrust_low = 1'b1;
		end else if ($signed(throttle_demand) > $signed({1'b0, max_thrust})) begin
			item_next.thrust      = max_thrust;
			item_next.thrust_high = 1'b1;
		end else begin
			item_next.thrust = throttle_demand[30:0];
		end
	end

	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_next;
		end
	end

endmodule
`default_nettype wire

// ----- design/cgtm_queue.sv -----
// Short first-in first-out queue of classified demand sets.
`timescale 1ns / 1ps
`default_nettype none
module cgtm_queue
	import cgtm_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  cgtm_item_t      push_item,
	input  wire logic       pop,
	output cgtm_item_t      pop_item,
	output logic            full,
	output logic            empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cgtm_item_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ----- design/cgtm_back.sv -----
// Solver: yaw bound, gimbal angle solve and rotor commands for one demand set at a time.
`timescale 1ns / 1ps
`default_nettype none
module cgtm_back
	import cgtm_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  cgtm_cfg_t   cfg,
	input  wire logic   q_empty,
	input  cgtm_item_t  q_item,
	output logic        q_pop,
	output logic        res_valid,
	output cgtm_result_t res
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_TDSTART,
		S_TDWAIT,
		S_CLAMP,
		S_MUL2,
		S_SUM,
		S_DIV2START,
		S_DIV2WAIT,
		S_SCALE,
		S_OUT
	} state_t;

	state_t       state_q;
	logic         res_valid_q;
	cgtm_result_t res_q;
	cgtm_result_t res_next;

	// Item registers.
	logic [30:0]        thrust_q;
	logic signed [31:0] yaw_q;
	logic signed [31:0] roll_q;
	logic signed [31:0] pitch_q;
	logic               low_q;
	logic               high_q;
	logic               roll_hit_q;
	logic               pitch_hit_q;
	logic               yaw_hit_q;

	// Datapath registers.
	logic [61:0]        prod_td_q;
	logic [30:0]        lever_q;
	logic               td_ovf_q;
	logic [61:0]        lt2_q;
	logic [62:0]        td2_q;
	logic signed [63:0] lmx_q;
	logic signed [63:0] lmy_q;
	logic signed [63:0] tmx_q;
	logic signed [63:0] tmy_q;
	logic [62:0]        det_q;
	logic [63:0]        nx_q;
	logic [63:0]        ny_q;
	logic               ovx_q;
	logic               ovy_q;
	logic [36:0]        degx_q;
	logic [36:0]        degy_q;
	logic [49:0]        a_q;
	logic [49:0]        b_q;

	logic [30:0] lg_eff;
	logic [30:0] dg_eff;
	logic [61:0] lever_prod;
	logic [32:0] xa;
	logic [32:0] xa_neg;
	logic [31:0] xa_mag;
	logic [32:0] xb;
	logic [32:0] xb_neg;
	logic [31:0] xb_mag;
	logic [31:0] yaw_mag;
	logic [31:0] td_lim;
	logic signed [63:0] yaw_sq;
	logic [63:0] nx_mag;
	logic [63:0] ny_mag;
	logic [62:0] x_rem0;
	logic [62:0] y_rem0;
	logic [30:0] rx;
	logic [30:0] ry;
	logic [52:0] px;
	logic [52:0] py;
	logic [30:0] degx_c;
	logic [30:0] degy_c;
	logic [50:0] rot_diff;
	logic [50:0] rot_sum;
	logic signed [50:0] half_diff;
	logic signed [50:0] half_sum;

	logic        td_busy, a_busy, b_busy, x_busy, y_busy;
	logic [30:0] td_quot;
	logic [47:0] a_quot;
	logic [47:0] b_quot;
	logic [30:0] x_quot;
	logic [30:0] y_quot;

	assign lg_eff = (cfg.lift_gain == '0) ? 31'd1 : cfg.lift_gain;
	assign dg_eff = (cfg.drag_gain == '0) ? 31'd1 : cfg.drag_gain;

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign lever_prod = cfg.lever_arm * thrust_q;

	assign xa     = {2'b00, thrust_q} - {cfg.lift_offset[31], cfg.lift_offset};
	assign xa_neg = 33'd0 - xa;
	assign xa_mag = xa[32] ? xa_neg[31:0] : xa[31:0];
	assign xb     = {yaw_q[31], yaw_q} - {cfg.drag_offset[31], cfg.drag_offset};
	assign xb_neg = 33'd0 - xb;
	assign xb_mag = xb[32] ? xb_neg[31:0] : xb[31:0];

	assign yaw_mag = yaw_q[31] ? (32'd0 - yaw_q) : yaw_q;
	assign td_lim  = {1'b0, td_quot};
	assign yaw_sq  = yaw_q * yaw_q;

	assign nx_mag = nx_q[63] ? (64'd0 - nx_q) : nx_q;
	assign ny_mag = ny_q[63] ? (64'd0 - ny_q) : ny_q;
	assign x_rem0 = {15'd0, nx_mag[62:15]};
	assign y_rem0 = {15'd0, ny_mag[62:15]};

	assign rx = ovx_q ? 31'h7FFF_FFFF : x_quot;
	assign ry = ovy_q ? 31'h7FFF_FFFF : y_quot;
	assign px = rx * RAD_TO_DEG;
	assign py = ry * RAD_TO_DEG;

	assign degx_c = (degx_q > {6'd0, cfg.servo_limit}) ? cfg.servo_limit : degx_q[30:0];
	assign degy_c = (degy_q > {6'd0, cfg.servo_limit}) ? cfg.servo_limit : degy_q[30:0];

	// Halving truncates toward zero: odd negative values are rounded up first.
	assign rot_diff  = {a_q[49], a_q} - {b_q[49], b_q};
	assign rot_sum   = {a_q[49], a_q} + {b_q[49], b_q};
	assign half_diff = $signed(rot_diff + {50'd0, rot_diff[50]}) >>> 1;
	assign half_sum  = $signed(rot_sum + {50'd0, rot_sum[50]}) >>> 1;

	always_comb begin
		res_next                 = '0;
		res_next.upper_rotor_cmd = sat32(half_diff);
		res_next.lower_rotor_cmd = sat32(half_sum);
		res_next.thrust_low_hit  = low_q;
		res_next.thrust_high_hit = high_q;
		res_next.yaw_hit         = yaw_hit_q;
		res_next.roll_hit        = roll_hit_q;
		res_next.pitch_hit       = pitch_hit_q;
		if (det_q != '0) begin
			res_next.servo_x_angle = nx_q[63] ? (32'd0 - {1'b0, degx_c}) : {1'b0, degx_c};
			res_next.servo_y_angle = ny_q[63] ? (32'd0 - {1'b0, degy_c}) : {1'b0, degy_c};
		end
	end

	// Yaw bound: thrust * drag_gain / lift_gain, with the top half checked for overflow.
	cgtm_div #(.DW(31), .QW(31)) u_td_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == S_TDSTART),
		.den          (lg_eff),
		.rem_init     (prod_td_q[61:31]),
		.dividend_bits(prod_td_q[30:0]),
		.busy         (td_busy),
		.quot         (td_quot)
	);

	cgtm_div #(.DW(31), .QW(48)) u_a_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == S_MUL1),
		.den          (lg_eff),
		.rem_init     (31'd0),
		.dividend_bits({xa_mag, 16'd0}),
		.busy         (a_busy),
		.quot         (a_quot)
	);

	cgtm_div #(.DW(31), .QW(48)) u_b_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == S_DIV2START),
		.den          (dg_eff),
		.rem_init     (31'd0),
		.dividend_bits({xb_mag, 16'd0}),
		.busy         (b_busy),
		.quot         (b_quot)
	);

	cgtm_div #(.DW(63), .QW(31)) u_x_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == S_DIV2START),
		.den          (det_q),
		.rem_init     (x_rem0),
		.dividend_bits({nx_mag[14:0], 16'd0}),
		.busy         (x_busy),
		.quot         (x_quot)
	);

	cgtm_div #(.DW(63), .QW(31)) u_y_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == S_DIV2START),
		.den          (det_q),
		.rem_init     (y_rem0),
		.dividend_bits({ny_mag[14:0], 16'd0}),
		.busy         (y_busy),
		.quot         (y_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1:    state_q <= S_TDSTART;
				S_TDSTART: state_q <= S_TDWAIT;
				S_TDWAIT: begin
					if (!td_busy) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP:     state_q <= S_MUL2;
				S_MUL2:      state_q <= S_SUM;
				S_SUM:       state_q <= S_DIV2START;
				S_DIV2START: state_q <= S_DIV2WAIT;
				S_DIV2WAIT: begin
					if (!x_busy && !y_busy && !b_busy && !a_busy) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_OUT;
				S_OUT: begin
					state_q     <= S_IDLE;
					res_valid_q <= 1'b1;
					res_q       <= res_next;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			thrust_q    <= q_item.thrust;
			yaw_q       <= q_item.yaw;
			roll_q      <= q_item.roll;
			pitch_q     <= q_item.pitch;
			low_q       <= q_item.thrust_low;
			high_q      <= q_item.thrust_high;
			roll_hit_q  <= q_item.roll_hit;
			pitch_hit_q <= q_item.pitch_hit;
		end
		case (state_q)
			S_MUL1: begin
				prod_td_q <= thrust_q * cfg.drag_gain;
				lever_q   <= (|lever_prod[61:47]) ? 31'h7FFF_FFFF : lever_prod[46:16];
			end
			S_TDSTART: begin
				td_ovf_q <= prod_td_q[61:31] >= lg_eff;
			end
			S_CLAMP: begin
				// An overflowing bound is at least 2^31 and never clamps.
				yaw_hit_q <= !td_ovf_q && (yaw_mag > td_lim);
				if (!td_ovf_q && (yaw_mag > td_lim)) begin
					yaw_q <= yaw_q[31] ? (32'd0 - td_lim) : td_lim;
				end
			end
			S_MUL2: begin
				lt2_q <= lever_q * lever_q;
				td2_q <= yaw_sq[62:0];
				lmx_q <= $signed({1'b0, lever_q}) * roll_q;
				lmy_q <= $signed({1'b0, lever_q}) * pitch_q;
				tmx_q <= yaw_q * roll_q;
				tmy_q <= yaw_q * pitch_q;
			end
			S_SUM: begin
				det_q <= {1'b0, lt2_q} + td2_q;
				nx_q  <= tmy_q - lmx_q;
				ny_q  <= tmx_q + lmy_q;
			end
			S_DIV2START: begin
				ovx_q <= x_rem0 >= det_q;
				ovy_q <= y_rem0 >= det_q;
			end
			S_SCALE: begin
				degx_q <= px[52:16];
				degy_q <= py[52:16];
				a_q    <= xa[32] ? (50'd0 - {2'b00, a_quot}) : {2'b00, a_quot};
				b_q    <= xb[32] ? (50'd0 - {2'b00, b_quot}) : {2'b00, b_quot};
			end
			default: ;
		endcase
	end

	a_result_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $past(state_q == S_OUT))
		else $error("result strobe without a finished solve");

	a_angle_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ($signed(res_q.servo_x_angle) <= $signed({1'b0, cfg.servo_limit})
			&& $signed(res_q.servo_x_angle) >= $signed(32'd0 - {1'b0, cfg.servo_limit})
			&& $signed(res_q.servo_y_angle) <= $signed({1'b0, cfg.servo_limit})
			&& $signed(res_q.servo_y_angle) >= $signed(32'd0 - {1'b0, cfg.servo_limit})))
		else $error("servo angle beyond its limit");

	a_thrust_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.thrust_low_hit && res_q.thrust_high_hit))
		else $error("thrust raised and clamped in the same result");

	a_dividers_idle_at_scale: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCALE |-> !(a_busy || b_busy || x_busy || y_busy || td_busy))
		else $error("quotient used while a divider is still running");

endmodule
`default_nettype wire

// ----- design/coax_gimbal_thrust_mixer_core.sv -----
// Top level of the coaxial gimbal thrust mixer: configuration registers, front end, queue, solver.
`timescale 1ns / 1ps
`default_nettype none
// A demand set is taken at a rising edge with start high and busy low. The front end sums the
// feed-forward terms and applies the thrust and moment clamps, registers the set and hands it to
// a queue of Q_DEPTH entries, so start can be given again at once while the solver works, as
// long as the queue has room. The solver handles one set at a time: two one-bit-per-cycle
// divides lie in line, the 31-bit yaw bound (thrust * drag_gain / lift_gain), with a 48-bit lift
// divide beside it, and then the 48-bit rotor torque divide that runs beside the two 31-bit
// gimbal angle divides.
// Each result is shown for exactly one cycle with result_valid high and the receiver cannot
// stall it, so it must capture every transfer when it comes. The flag outputs belong to that
// result only and are not latched. Configuration registers are written through cfg_we, cfg_idx
// and cfg_wdata at any edge with cfg_we high; write them only while no set is in flight.
module coax_gimbal_thrust_mixer_core
	import cgtm_pkg::*;
#(
	parameter int unsigned Q_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [31:0]           throttle_demand,
	input  wire logic [31:0]           roll_demand,
	input  wire logic [31:0]           roll_feedfwd,
	input  wire logic [31:0]           pitch_demand,
	input  wire logic [31:0]           pitch_feedfwd,
	input  wire logic [31:0]           yaw_demand,
	input  wire logic [31:0]           yaw_feedfwd,
	output logic                       result_valid,
	output logic [31:0]                servo_x_angle,
	output logic [31:0]                servo_y_angle,
	output logic [31:0]                upper_rotor_cmd,
	output logic [31:0]                lower_rotor_cmd,
	output logic                       thrust_low_hit,
	output logic                       thrust_high_hit,
	output logic                       yaw_hit,
	output logic                       roll_hit,
	output logic                       pitch_hit
);
	cgtm_cfg_t    cfg_q;
	cgtm_item_t   push_item;
	cgtm_item_t   pop_item;
	cgtm_result_t res;
	logic         q_push;
	logic         q_pop;
	logic         q_full;
	logic         q_empty;

	// Unsigned registers keep the low 31 bits of the write data; offsets keep all 32.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lift_gain   <= RST_LIFT_GAIN;
			cfg_q.drag_gain   <= RST_DRAG_GAIN;
			cfg_q.lift_offset <= RST_LIFT_OFFSET;
			cfg_q.drag_offset <= RST_DRAG_OFFSET;
			cfg_q.lever_arm   <= RST_LEVER_ARM;
			cfg_q.max_thrust  <= RST_MAX_THRUST;
			cfg_q.max_moment  <= RST_MAX_MOMENT;
			cfg_q.servo_limit <= RST_SERVO_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LIFT_GAIN:   cfg_q.lift_gain   <= cfg_wdata[30:0];
				REG_DRAG_GAIN:   cfg_q.drag_gain   <= cfg_wdata[30:0];
				REG_LIFT_OFFSET: cfg_q.lift_offset <= cfg_wdata;
				REG_DRAG_OFFSET: cfg_q.drag_offset <= cfg_wdata;
				REG_LEVER_ARM:   cfg_q.lever_arm   <= cfg_wdata[30:0];
				REG_MAX_THRUST:  cfg_q.max_thrust  <= cfg_wdata[30:0];
				REG_MAX_MOMENT:  cfg_q.max_moment  <= cfg_wdata[30:0];
				REG_SERVO_LIMIT: cfg_q.servo_limit <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// Front end: accepts a transfer and classifies it against the clamps.
	cgtm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.throttle_demand(throttle_demand),
		.roll_demand    (roll_demand),
		.roll_feedfwd   (roll_feedfwd),
		.pitch_demand   (pitch_demand),
		.pitch_feedfwd  (pitch_feedfwd),
		.yaw_demand     (yaw_demand),
		.yaw_feedfwd    (yaw_feedfwd),
		.max_thrust     (cfg_q.max_thrust),
		.max_moment     (cfg_q.max_moment),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_item         (push_item),
		.busy           (busy)
	);

	// The queue lets the front end keep taking transfers while the solver is occupied.
	cgtm_queue #(.DEPTH(Q_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.pop      (q_pop),
		.pop_item (pop_item),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Solver: yaw bound, angle solve and rotor commands, one result register at its end.
	cgtm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.q_pop    (q_pop),
		.res_valid(result_valid),
		.res      (res)
	);

	assign servo_x_angle   = res.servo_x_angle;
	assign servo_y_angle   = res.servo_y_angle;
	assign upper_rotor_cmd = res.upper_rotor_cmd;
	assign lower_rotor_cmd = res.lower_rotor_cmd;
	assign thrust_low_hit  = res.thrust_low_hit;
	assign thrust_high_hit = res.thrust_high_hit;
	assign yaw_hit         = res.yaw_hit;
	assign roll_hit        = res.roll_hit;
	assign pitch_hit       = res.pitch_hit;

endmodule
`default_nettype wire
